// File: design/mfm_pkg.sv
// Shared types and constants of the masked flow table.
package mfm_pkg;

   localparam int TABLE_ENTRIES    = 64;
   localparam int HEADER_REGIONS   = 8;
   localparam int WORDS_PER_REGION = 8;
   localparam int ENTRY_W          = 6;
   localparam int REGION_W         = 3;
   localparam int WORD_W           = 3;
   localparam int ROW_W            = ENTRY_W + REGION_W;
   localparam int ROWS             = TABLE_ENTRIES * HEADER_REGIONS;
   localparam int CLR_W            = ROW_W + 1;

   // Request modes
   localparam logic [2:0] MODE_MASK   = 3'd0;
   localparam logic [2:0] MODE_VALUE  = 3'd1;
   localparam logic [2:0] MODE_CTRL   = 3'd2;
   localparam logic [2:0] MODE_KEY    = 3'd3;
   localparam logic [2:0] MODE_SRCH   = 3'd4;
   localparam logic [2:0] MODE_READ   = 3'd5;
   localparam logic [2:0] MODE_SPARE6 = 3'd6;
   localparam logic [2:0] MODE_SPARE7 = 3'd7;

   // Register indexes
   localparam logic [1:0] CSR_ENTRIES = 2'd0;
   localparam logic [1:0] CSR_REGIONS = 2'd1;

   typedef struct packed {
      logic [2:0]  mode;
      logic [5:0]  entry_index;
      logic [2:0]  region_index;
      logic [2:0]  word_index;
      logic [31:0] data_word;
      logic [7:0]  word_enables;
      logic        pkt_off;
      logic        bytes_off;
      logic [7:0]  region_present;
      logic        is_ipv6;
      logic [15:0] packet_length;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic [5:0]  match_index;
      logic [63:0] pkt_total;
      logic [63:0] byte_total;
   } rsp_type;

   // Write command to the rule row memory
   typedef struct packed {
      logic             mask_we;
      logic             value_we;
      logic             en_we;
      logic [ROW_W-1:0] addr;
      logic [WORD_W-1:0] lane;
      logic [31:0]      data;
      logic [7:0]       en;
   } row_wr_type;

   // Write command to the counter memory
   typedef struct packed {
      logic               we;
      logic [ENTRY_W-1:0] addr;
      logic [63:0]        pkt;
      logic [63:0]        bytes;
   } cnt_wr_type;

endpackage

// File: design/mfm_row_mem.sv
// Rule row memory: mask and value lanes plus the word-enable byte per entry and region.
module mfm_row_mem
   import mfm_pkg::*;
(
   input  logic             clock,
   input  row_wr_type       wr,
   input  logic [ROW_W-1:0] rd_addr,
   output logic [31:0]      mask_rd [WORDS_PER_REGION],
   output logic [31:0]      value_rd [WORDS_PER_REGION],
   output logic [7:0]       en_rd
);

   logic [7:0] en_mem [ROWS];

   // Enable byte store
   always_ff @(posedge clock) begin
      if (wr.en_we) begin
         en_mem[wr.addr] <= wr.en;
      end
      en_rd <= en_mem[rd_addr];
   end

   // One mask and one value memory per word lane
   for (genvar w = 0; w < WORDS_PER_REGION; w++) begin : g_lane
      logic [31:0] mask_mem [ROWS];
      logic [31:0] value_mem [ROWS];

      always_ff @(posedge clock) begin
         if (wr.mask_we && wr.lane == WORD_W'(w)) begin
            mask_mem[wr.addr] <= wr.data;
         end
         if (wr.value_we && wr.lane == WORD_W'(w)) begin
            value_mem[wr.addr] <= wr.data;
         end
         mask_rd[w]  <= mask_mem[rd_addr];
         value_rd[w] <= value_mem[rd_addr];
      end
   end

endmodule

// File: design/mfm_count_mem.sv
// Packet and byte counter memory, one row per entry.
module mfm_count_mem
   import mfm_pkg::*;
(
   input  logic               clock,
   input  cnt_wr_type         wr,
   input  logic [ENTRY_W-1:0] rd_addr,
   output logic [63:0]        pkt_rd,
   output logic [63:0]        bytes_rd
);

   logic [127:0] mem [TABLE_ENTRIES];

   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem[wr.addr] <= {wr.pkt, wr.bytes};
      end
      {pkt_rd, bytes_rd} <= mem[rd_addr];
   end

endmodule

// File: design/masked_flow_table_first_match.sv
// Top level of the masked flow table with first-match search and counters.
//
//   channel  direction  handshake       payload
//   req      in         valid / stall   req_type
//   rsp      out        valid / stall   rsp_type
//   csr      in         valid / ready   index, data
//
// A search reads one region row per cycle from the rule memory and moves on to
// the next entry as soon as a region of the current entry fails. After reset a
// sweep clears the enable memory and counters; requests stall meanwhile. A
// stalled response holds the block.
module masked_flow_table_first_match
   import mfm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [6:0]  csr_data
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SEARCH = 5'b00010,
      ST_CNT_RD = 5'b00100,
      ST_CNT_WR = 5'b01000,
      ST_RESP   = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [6:0]         entries_ff;
   logic [3:0]         regions_ff;
   logic [CLR_W-1:0]   clr_ff;
   logic [31:0]        key_ff [HEADER_REGIONS][WORDS_PER_REGION];
   logic [1:0]         flags_mem [TABLE_ENTRIES];
   logic [1:0]         flags_rd;

   logic [6:0]         n_ff, n_in;
   logic [3:0]         nreg_ff, nreg_in;
   logic [7:0]         present_ff, present_in;
   logic [15:0]        len_ff, len_in;
   logic               srch_ff, srch_in;
   logic [ENTRY_W-1:0] cidx_ff, cidx_in;
   logic [ENTRY_W-1:0] ie_ff, ie_in, pe_ff, pe_in;
   logic [REGION_W-1:0] ir_ff, ir_in, pr_ff, pr_in;
   logic               iv_ff, iv_in, sv_ff, sv_in;
   rsp_type            res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               clearing, rsp_free, accept;
   row_wr_type         row_wr;
   cnt_wr_type         cnt_wr;
   logic [ROW_W-1:0]   row_rd_addr;
   logic [31:0]        mask_rd [WORDS_PER_REGION];
   logic [31:0]        value_rd [WORDS_PER_REGION];
   logic [7:0]         en_rd;
   logic [63:0]        pkt_rd, bytes_rd;
   logic               mism, fail, last;
   logic [ENTRY_W-1:0] a_e;
   logic [REGION_W-1:0] a_r;
   logic               a_v;

   assign clearing  = !clr_ff[CLR_W-1];
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = clearing || (state_ff != ST_IDLE) || !rsp_free;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   mfm_row_mem u_row_mem (
      .clock    (clock),
      .wr       (row_wr),
      .rd_addr  (row_rd_addr),
      .mask_rd  (mask_rd),
      .value_rd (value_rd),
      .en_rd    (en_rd)
   );

   mfm_count_mem u_count_mem (
      .clock    (clock),
      .wr       (cnt_wr),
      .rd_addr  (cidx_ff),
      .pkt_rd   (pkt_rd),
      .bytes_rd (bytes_rd)
   );

   // Row write port: clear sweep or rule loads
   always_comb begin
      row_wr          = '0;
      row_wr.addr     = {req_data.entry_index, req_data.region_index};
      row_wr.lane     = req_data.word_index;
      row_wr.data     = req_data.data_word;
      row_wr.en       = req_data.word_enables;
      if (clearing) begin
         row_wr.en_we = 1'b1;
         row_wr.addr  = clr_ff[ROW_W-1:0];
         row_wr.en    = '0;
      end else if (accept) begin
         row_wr.mask_we  = req_data.mode == MODE_MASK;
         row_wr.value_we = req_data.mode == MODE_VALUE;
         row_wr.en_we    = req_data.mode == MODE_CTRL;
      end
   end

   // Count-suppress flags per entry, cleared by the sweep, read with the counters
   always_ff @(posedge clock) begin
      if (clearing) begin
         flags_mem[clr_ff[ENTRY_W-1:0]] <= '0;
      end else if (accept && req_data.mode == MODE_CTRL) begin
         flags_mem[req_data.entry_index] <= {req_data.bytes_off, req_data.pkt_off};
      end
      flags_rd <= flags_mem[cidx_ff];
   end

   // Compare one region row against the key
   always_comb begin
      mism = 1'b0;
      for (int w = 0; w < WORDS_PER_REGION; w++) begin
         if (en_rd[w] && ((key_ff[pr_ff][w] & mask_rd[w]) != value_rd[w])) begin
            mism = 1'b1;
         end
      end
      fail = (en_rd != 8'd0) && (!present_ff[pr_ff] || mism);
      last = ({1'b0, pr_ff} + 4'd1) == nreg_ff;
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      nreg_in      = nreg_ff;
      present_in   = present_ff;
      len_in       = len_ff;
      srch_in      = srch_ff;
      cidx_in      = cidx_ff;
      ie_in        = ie_ff;
      ir_in        = ir_ff;
      iv_in        = iv_ff;
      pe_in        = pe_ff;
      pr_in        = pr_ff;
      sv_in        = 1'b0;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      row_rd_addr  = {ie_ff, ir_ff};
      cnt_wr       = '0;
      a_e          = ie_ff;
      a_r          = ir_ff;
      a_v          = iv_ff;
      if (clearing) begin
         cnt_wr.we   = 1'b1;
         cnt_wr.addr = clr_ff[ENTRY_W-1:0];
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               present_in = req_data.region_present;
               len_in     = req_data.packet_length;
               res_in     = '0;
               if (req_data.mode == MODE_SRCH) begin
                  n_in    = (entries_ff > 7'(TABLE_ENTRIES)) ? 7'(TABLE_ENTRIES)
                                                               : entries_ff;
                  nreg_in = (req_data.is_ipv6 || regions_ff > 4'(HEADER_REGIONS))
                            ? 4'(HEADER_REGIONS) : regions_ff;
                  srch_in = 1'b1;
                  ie_in   = '0;
                  ir_in   = '0;
                  iv_in   = 1'b1;
                  cidx_in = '0;
                  if (n_in == 7'd0) begin
                     state_in = ST_RESP;
                  end else if (nreg_in == 4'd0) begin
                     state_in = ST_CNT_RD;
                  end else begin
                     state_in = ST_SEARCH;
                  end
               end else if (req_data.mode == MODE_READ) begin
                  srch_in  = 1'b0;
                  cidx_in  = req_data.entry_index;
                  state_in = ST_CNT_RD;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '0;
               end
            end
         end
         ST_SEARCH: begin
            if (sv_ff && !fail && last) begin
               cidx_in  = pe_ff;
               state_in = ST_CNT_RD;
            end else if (sv_ff && fail && ({1'b0, pe_ff} + 7'd1) == n_ff) begin
               state_in = ST_RESP;
            end else begin
               if (sv_ff && fail) begin
                  a_e = pe_ff + ENTRY_W'(1);
                  a_r = '0;
                  a_v = 1'b1;
               end
               if (a_v) begin
                  row_rd_addr = {a_e, a_r};
                  pe_in       = a_e;
                  pr_in       = a_r;
                  sv_in       = 1'b1;
                  if (({1'b0, a_r} + 4'd1) == nreg_ff) begin
                     ie_in = a_e + ENTRY_W'(1);
                     ir_in = '0;
                     iv_in = ({1'b0, a_e} + 7'd1) < n_ff;
                  end else begin
                     ie_in = a_e;
                     ir_in = a_r + REGION_W'(1);
                     iv_in = 1'b1;
                  end
               end else if (!sv_ff) begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_CNT_RD: begin
            state_in = ST_CNT_WR;
         end
         ST_CNT_WR: begin
            res_in.pkt_total  = pkt_rd;
            res_in.byte_total = bytes_rd;
            if (srch_ff) begin
               res_in.hit         = 1'b1;
               res_in.match_index = cidx_ff;
               if (!flags_rd[0]) begin
                  res_in.pkt_total = pkt_rd + 64'd1;
               end
               if (!flags_rd[1]) begin
                  res_in.byte_total = bytes_rd + {48'd0, len_ff};
               end
               cnt_wr.we    = 1'b1;
               cnt_wr.addr  = cidx_ff;
               cnt_wr.pkt   = res_in.pkt_total;
               cnt_wr.bytes = res_in.byte_total;
            end
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         clr_ff       <= '0;
         entries_ff   <= '0;
         regions_ff   <= 4'd8;
         sv_ff        <= 1'b0;
         iv_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         sv_ff        <= sv_in;
         iv_ff        <= iv_in;
         if (clearing) begin
            clr_ff <= clr_ff + CLR_W'(1);
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_ENTRIES) begin
               entries_ff <= csr_data;
            end else if (csr_index == CSR_REGIONS) begin
               regions_ff <= csr_data[3:0];
            end
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      n_ff       <= n_in;
      nreg_ff    <= nreg_in;
      present_ff <= present_in;
      len_ff     <= len_in;
      srch_ff    <= srch_in;
      cidx_ff    <= cidx_in;
      ie_ff      <= ie_in;
      ir_ff      <= ir_in;
      pe_ff      <= pe_in;
      pr_ff      <= pr_in;
      res_ff     <= res_in;
      rsp_ff     <= rsp_in;
      if (accept && req_data.mode == MODE_KEY) begin
         key_ff[req_data.region_index][req_data.word_index] <= req_data.data_word;
      end
   end

endmodule
